@@ hdl/csem_pkg.sv @@
package csem_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int SEM_ID_W   = 6;
   localparam int COUNT_W    = 16;
   localparam int TASK_W     = 4;
   localparam int STATUS_W   = 2;

   localparam int DEF_NUM_SEMS  = 32;
   localparam int DEF_NUM_TASKS = 16;

   localparam logic [REQ_TYPE_W-1:0] REQ_INIT    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WAIT    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SIGNAL  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_DESTROY = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_PERM  = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TASK_W-1:0]  head;
      logic [TASK_W-1:0]  tail;
   } sem_entry_type;

   localparam int ENTRY_W = $bits(sem_entry_type);

endpackage

@@ hdl/csem_if.sv @@
interface csem_req_if import csem_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SEM_ID_W-1:0]   sem_id;
   logic [COUNT_W-1:0]    init_value;
   logic [TASK_W-1:0]     caller_task;

   modport source (output valid, req_type, sem_id, init_value, caller_task, input ready);
   modport sink   (input valid, req_type, sem_id, init_value, caller_task, output ready);
endinterface

interface csem_rsp_if import csem_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                caller_blocked;
   logic                woken_valid;
   logic [TASK_W-1:0]   woken_task;

   modport source (output valid, status, caller_blocked, woken_valid, woken_task,
                   input ready);
   modport sink   (input valid, status, caller_blocked, woken_valid, woken_task,
                   output ready);
endinterface

@@ hdl/csem_ram.sv @@
module csem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

@@ hdl/csem_ctrl.sv @@
module csem_ctrl import csem_pkg::*; #(
   parameter int NUM_SEMS  = DEF_NUM_SEMS,
   parameter int NUM_TASKS = DEF_NUM_TASKS,
   localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1,
   localparam int TASK_AW = $clog2(NUM_TASKS)
) (
   input  logic                clock,
   input  logic                reset,
   csem_req_if.sink            req_ch,
   csem_rsp_if.source          rsp_ch,
   output logic [SEM_AW-1:0]   sem_raddr,
   output logic                sem_we,
   output logic [SEM_AW-1:0]   sem_waddr,
   output sem_entry_type       sem_wdata,
   input  sem_entry_type       sem_rdata,
   output logic [TASK_AW-1:0]  wn_raddr,
   output logic                wn_we,
   output logic [TASK_AW-1:0]  wn_waddr,
   output logic [TASK_W-1:0]   wn_wdata,
   input  logic [TASK_W-1:0]   wn_rdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [REQ_TYPE_W-1:0] op_ff;
   logic                  in_range_ff;
   logic [SEM_AW-1:0]     sem_ff;
   logic [COUNT_W-1:0]    ival_ff;
   logic [TASK_W-1:0]     caller_ff;
   logic [NUM_SEMS-1:0]   live_ff, live_in;
   logic [NUM_SEMS-1:0]   nonempty_ff, nonempty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  blocked_ff, blocked_in;
   logic                  wvalid_ff, wvalid_in;
   logic [TASK_W-1:0]     wtask_ff, wtask_in;

   logic                  req_fire;
   logic                  req_in_range;
   logic                  caller_ok;
   logic                  cur_live;
   logic                  cur_nonempty;
   logic [TASK_W-1:0]     head_slot;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_in_range = ({1'b0, req_ch.sem_id} < (SEM_ID_W + 1)'(NUM_SEMS));

   // entry stays addressed after acceptance so read data holds through the link step
   assign sem_raddr = (state_ff == S_IDLE)
                      ? (req_in_range ? req_ch.sem_id[SEM_AW-1:0] : '0)
                      : sem_ff;
   assign wn_raddr  = sem_rdata.head[TASK_AW-1:0];

   assign caller_ok    = ({1'b0, caller_ff} < (TASK_W + 1)'(NUM_TASKS));
   assign cur_live     = live_ff[sem_ff];
   assign cur_nonempty = nonempty_ff[sem_ff];
   assign head_slot    = ({1'b0, sem_rdata.head} < (TASK_W + 1)'(NUM_TASKS))
                         ? sem_rdata.head : '0;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.caller_blocked = blocked_ff;
   assign rsp_ch.woken_valid    = wvalid_ff;
   assign rsp_ch.woken_task     = wtask_ff;

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      nonempty_in  = nonempty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      blocked_in   = blocked_ff;
      wvalid_in    = wvalid_ff;
      wtask_in     = wtask_ff;
      sem_we       = 1'b0;
      sem_waddr    = sem_ff;
      sem_wdata    = sem_rdata;
      wn_we        = 1'b0;
      wn_waddr     = sem_rdata.tail[TASK_AW-1:0];
      wn_wdata     = caller_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            blocked_in   = 1'b0;
            wvalid_in    = 1'b0;
            wtask_in     = '0;
            if (!in_range_ff) begin
               status_in = ST_INVAL;
            end else if (op_ff == REQ_INIT) begin
               if (cur_live) begin
                  status_in = ST_BUSY;
               end else begin
                  sem_we                = 1'b1;
                  sem_wdata.count       = ival_ff;
                  nonempty_in[sem_ff]   = 1'b0;
                  live_in[sem_ff]       = 1'b1;
               end
            end else if (!cur_live) begin
               status_in = ST_INVAL;
            end else if (op_ff == REQ_WAIT) begin
               if (!caller_ok) begin
                  status_in = ST_INVAL;
               end else if (caller_ff == '0) begin
                  status_in = ST_PERM;
               end else if (sem_rdata.count != '0) begin
                  sem_we          = 1'b1;
                  sem_wdata.count = sem_rdata.count - COUNT_W'(1);
               end else begin
                  sem_we         = 1'b1;
                  sem_wdata.tail = caller_ff;
                  blocked_in     = 1'b1;
                  if (cur_nonempty) begin
                     wn_we = 1'b1;
                  end else begin
                     sem_wdata.head      = caller_ff;
                     nonempty_in[sem_ff] = 1'b1;
                  end
               end
            end else if (op_ff == REQ_SIGNAL) begin
               if (cur_nonempty) begin
                  wvalid_in = 1'b1;
                  wtask_in  = head_slot;
                  if (sem_rdata.head == sem_rdata.tail) begin
                     nonempty_in[sem_ff] = 1'b0;
                  end else begin
                     // next waiter comes out of the link memory in the following cycle, in S_LINK
                     state_in     = S_LINK;
                     rsp_valid_in = 1'b0;
                  end
               end else if (sem_rdata.count != COUNT_MAX) begin
                  sem_we          = 1'b1;
                  sem_wdata.count = sem_rdata.count + COUNT_W'(1);
               end
            end else begin
               if (cur_nonempty) begin
                  status_in = ST_BUSY;
               end else begin
                  live_in[sem_ff] = 1'b0;
               end
            end
         end
         S_LINK: begin
            state_in       = S_IDLE;
            rsp_valid_in   = 1'b1;
            sem_we         = 1'b1;
            sem_wdata.head = wn_rdata;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_ch.req_type;
         in_range_ff <= req_in_range;
         sem_ff      <= req_in_range ? req_ch.sem_id[SEM_AW-1:0] : '0;
         ival_ff     <= req_ch.init_value;
         caller_ff   <= req_ch.caller_task;
      end
      status_ff  <= status_in;
      blocked_ff <= blocked_in;
      wvalid_ff  <= wvalid_in;
      wtask_ff   <= wtask_in;
   end

endmodule

@@ hdl/counting_semaphore_table_unit.sv @@
// Channel  Dir  Word                                          Handshake
// req_ch   in   req_type, sem_id, init_value, caller_task     valid/ready
// rsp_ch   out  status, caller_blocked, woken_valid, woken_task valid/ready
//
// One request at a time: each word is accepted, then the semaphore entry is
// read-modify-written; a signal that dequeues from a queue holding more than
// one waiter adds a step in which the next waiter is read from the link memory
// after the entry read. One response per request, held in an output register.
// Synchronous reset clears the live and queue-occupied flags; no memory sweep.
// A stalled response blocks further requests until it is taken.
module counting_semaphore_table_unit import csem_pkg::*; #(
   parameter int NUM_SEMS  = DEF_NUM_SEMS,
   parameter int NUM_TASKS = DEF_NUM_TASKS
) (
   input  logic       clock,
   input  logic       reset,
   csem_req_if.sink   req_ch,
   csem_rsp_if.source rsp_ch
);

   localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int TASK_AW = $clog2(NUM_TASKS);

   logic [SEM_AW-1:0]  sem_raddr;
   logic               sem_we;
   logic [SEM_AW-1:0]  sem_waddr;
   sem_entry_type      sem_wdata;
   sem_entry_type      sem_rdata;
   logic [TASK_AW-1:0] wn_raddr;
   logic               wn_we;
   logic [TASK_AW-1:0] wn_waddr;
   logic [TASK_W-1:0]  wn_wdata;
   logic [TASK_W-1:0]  wn_rdata;

   csem_ctrl #(
      .NUM_SEMS  (NUM_SEMS),
      .NUM_TASKS (NUM_TASKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .sem_raddr (sem_raddr),
      .sem_we    (sem_we),
      .sem_waddr (sem_waddr),
      .sem_wdata (sem_wdata),
      .sem_rdata (sem_rdata),
      .wn_raddr  (wn_raddr),
      .wn_we     (wn_we),
      .wn_waddr  (wn_waddr),
      .wn_wdata  (wn_wdata),
      .wn_rdata  (wn_rdata)
   );

   csem_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SEMS)
   ) u_sem_ram (
      .clock    (clock),
      .we       (sem_we),
      .waddr    (sem_waddr),
      .wdata    (sem_wdata),
      .raddr    (sem_raddr),
      .rdata_ff (sem_rdata)
   );

   csem_ram #(
      .WIDTH (TASK_W),
      .DEPTH (NUM_TASKS)
   ) u_link_ram (
      .clock    (clock),
      .we       (wn_we),
      .waddr    (wn_waddr),
      .wdata    (wn_wdata),
      .raddr    (wn_raddr),
      .rdata_ff (wn_rdata)
   );

`ifndef SYNTHESIS
   a_blocked_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.caller_blocked |->
         rsp_ch.status == ST_OK && !rsp_ch.woken_valid)
      else $error("blocked response with bad status or wake");

   a_wake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.woken_valid |-> rsp_ch.woken_task == '0)
      else $error("woken_task set without woken_valid");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while another is in flight");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !rsp_ch.valid)
      else $error("output register occupied after accept");
`endif

endmodule
